FILE: design/mtke_pkg.sv
// Package for the multitap keypad text entry unit.
// Holds the item and result types, key codes and the per-key character tables.
// No dependencies.
package mtke_pkg;

    localparam logic [3:0] NO_KEY   = 4'd15;
    localparam logic [3:0] KEY_STAR = 4'd10;

    typedef enum logic [0:0] {
        ACT_PRESS   = 1'b0,
        ACT_CONFIRM = 1'b1
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [3:0] key;
    } t_item;

    typedef struct packed {
        logic       emitted;
        logic [7:0] emitted_char;
        logic       tap_active;
        logic [7:0] current_char;
    } t_result;

    typedef logic [0:4][7:0] t_row;

    localparam t_row KEY_ROWS [16] = '{
        '{" ", "0", 8'h00, 8'h00, 8'h00},
        '{".", ",", "!", "?", "1"},
        '{"a", "b", "c", "2", 8'h00},
        '{"d", "e", "f", "3", 8'h00},
        '{"g", "h", "i", "4", 8'h00},
        '{"j", "k", "l", "5", 8'h00},
        '{"m", "n", "o", "6", 8'h00},
        '{"p", "q", "r", "s", "7"},
        '{"t", "u", "v", "8", 8'h00},
        '{"w", "x", "y", "z", "9"},
        '{"*", 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KEY_COUNTS [16] = '{
        3'd2, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5,
        3'd4, 3'd5, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

    function automatic logic [7:0] key_char(logic [3:0] key, logic [2:0] pos);
        t_row row;
        logic [7:0] ch;
        begin
            row = KEY_ROWS[key];
            case (pos)
                3'd0: ch = row[0];
                3'd1: ch = row[1];
                3'd2: ch = row[2];
                3'd3: ch = row[3];
                3'd4: ch = row[4];
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

FILE: design/mtke_seq.sv
// Multitap sequence state and its single-pass update for one item.
// Depends on mtke_pkg for types, key codes and character tables.
module mtke_seq
    import mtke_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    logic [3:0] r_held_key, n_held_key;
    logic [2:0] r_pos, n_pos;
    logic       r_active, n_active;
    logic [7:0] r_pending, n_pending;
    logic       emit;
    logic [7:0] emit_code;
    logic [2:0] step_pos;

    always_comb begin
        n_held_key = r_held_key;
        n_pos      = r_pos;
        n_active   = r_active;
        n_pending  = r_pending;
        emit       = 1'b0;
        emit_code  = 8'h00;
        step_pos   = r_pos + 3'd1;
        if (step_pos >= KEY_COUNTS[i_item.key]) begin
            step_pos = 3'd0;
        end
        if (i_item.action == ACT_CONFIRM) begin
            if (r_active) begin
                emit       = 1'b1;
                emit_code  = r_pending;
                n_held_key = NO_KEY;
                n_pos      = 3'd0;
                n_active   = 1'b0;
                n_pending  = 8'h00;
            end
        end else if (i_item.key <= KEY_STAR) begin
            if (r_active && i_item.key == r_held_key) begin
                n_pos     = step_pos;
                n_pending = key_char(i_item.key, step_pos);
            end else begin
                if (r_active) begin
                    emit      = 1'b1;
                    emit_code = r_pending;
                end
                n_held_key = i_item.key;
                n_pos      = 3'd0;
                n_active   = 1'b1;
                n_pending  = key_char(i_item.key, 3'd0);
            end
        end
        o_result.emitted      = emit;
        o_result.emitted_char = emit_code;
        o_result.tap_active   = n_active;
        o_result.current_char = n_active ? n_pending : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_key <= NO_KEY;
            r_pos      <= 3'd0;
            r_active   <= 1'b0;
            r_pending  <= 8'h00;
        end else if (i_step) begin
            r_held_key <= n_held_key;
            r_pos      <= n_pos;
            r_active   <= n_active;
            r_pending  <= n_pending;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_held_key == NO_KEY && r_pos == 3'd0 && r_pending == 8'h00))
        else $error("idle state not cleared");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_held_key <= KEY_STAR && r_pos < KEY_COUNTS[r_held_key]))
        else $error("held key or position out of range");

    a_pending_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_pending == key_char(r_held_key, r_pos))
        else $error("pending character does not match table");

    a_confirm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.action == ACT_CONFIRM) |=> !r_active)
        else $error("confirm did not end the sequence");

endmodule

FILE: design/multitap_keypad_text_entry_unit.sv
// Multitap keypad text entry: input register, sequence update, result register.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while results are taken; the input register
// takes one more request while a result waits, then the input side stalls.
// Reset (synchronous, active low) empties both registers and ends any sequence.
// Depends on mtke_pkg and mtke_seq.
module multitap_keypad_text_entry_unit
    import mtke_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] key, [7:4] zero
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [0] emitted, [8:1] emitted_char,
                                        // [9] tap_active, [17:10] current_char,
                                        // [23:18] zero
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.action <= t_action'(s_axis_tuser);
            r_item.key    <= s_axis_tdata[3:0];
        end
    end

    mtke_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_item),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.current_char, r_out.tap_active,
                            r_out.emitted_char, r_out.emitted};

endmodule

FILE: bench/multitap_keypad_text_entry_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for multitap_keypad_text_entry_unit: key presses and confirms go in
// as requests and every report is checked against a local model of the multitap state.
// Depends on mtke_pkg and the unit's RTL.
module multitap_keypad_text_entry_unit_test;
    import mtke_pkg::*;

    localparam int TOTAL_REQS  = 1850;
    localparam int TAIL_REQS   = 200;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_SHOWN   = 10;
    localparam logic [3:0] KEY_HASH = 4'd11;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    string key_letters [11] = '{" 0", ".,!?1", "abc2", "def3", "ghi4", "jkl5",
                                "mno6", "pqrs7", "tuv8", "wxyz9", "*"};

    logic [3:0] held_key = NO_KEY;
    logic [2:0] tap_pos = 3'd0;
    logic       seq_on = 1'b0;
    logic [7:0] model_char = 8'h00;

    t_item   pending_keys [$];
    t_result expected_reports [$];
    int      reqs_accepted = 0;
    int      total_reqs = 0;
    int      bad_reports = 0;
    int      send_gap = 0;
    int      ready_gap = 0;
    logic    in_fire = 1'b0;
    logic    hold_off = 1'b0;

    multitap_keypad_text_entry_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic queue_press(input logic [3:0] k);
        t_item r;
        r.action = ACT_PRESS;
        r.key = k;
        pending_keys.push_back(r);
    endtask

    task automatic queue_confirm(input logic [3:0] k);
        t_item r;
        r.action = ACT_CONFIRM;
        r.key = k;
        pending_keys.push_back(r);
    endtask

    task automatic apply_keystroke(input t_item req);
        t_result res;
        int      next_pos;
        res = '0;
        if (req.action == ACT_CONFIRM) begin
            if (seq_on) begin
                res.emitted = 1'b1;
                res.emitted_char = model_char;
                held_key = NO_KEY;
                tap_pos = 3'd0;
                seq_on = 1'b0;
                model_char = 8'h00;
            end
        end else if (req.key <= KEY_STAR) begin
            if (seq_on && req.key == held_key) begin
                next_pos = tap_pos + 1;
                if (next_pos >= key_letters[req.key].len()) begin
                    next_pos = 0;
                end
                tap_pos = next_pos[2:0];
                model_char = key_letters[req.key][next_pos];
            end else begin
                if (seq_on) begin
                    res.emitted = 1'b1;
                    res.emitted_char = model_char;
                end
                held_key = req.key;
                tap_pos = 3'd0;
                seq_on = 1'b1;
                model_char = key_letters[req.key][0];
            end
        end
        res.tap_active = seq_on;
        res.current_char = seq_on ? model_char : 8'h00;
        expected_reports.push_back(res);
    endtask

    task automatic note_failure(input string what, input logic [23:0] want,
                                input logic [23:0] got);
        bad_reports++;
        if (bad_reports <= MAX_SHOWN) begin
            $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    task automatic check_report(input logic [23:0] got);
        t_result     want;
        logic [23:0] want_word;
        if (expected_reports.size() == 0) begin
            note_failure("report with nothing pending", 24'h0, got);
        end else begin
            want = expected_reports.pop_front();
            want_word = {6'd0, want.current_char, want.tap_active,
                         want.emitted_char, want.emitted};
            if (got !== want_word) begin
                note_failure("report", want_word, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_item req;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_report(m_axis_tdata);
        end
        if (in_fire) begin
            req.action = t_action'(s_axis_tuser);
            req.key = s_axis_tdata[3:0];
            apply_keystroke(req);
            reqs_accepted++;
        end
    end

    always @(negedge i_clk) begin
        t_item req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_keys.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending_keys.size() > TAIL_REQS && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 8);
                s_axis_tvalid <= 1'b0;
            end else begin
                req = pending_keys.pop_front();
                s_axis_tdata <= {4'd0, req.key};
                s_axis_tuser <= req.action;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_axis_tready <= 1'b0;
        end else if (pending_keys.size() > TAIL_REQS && $urandom_range(0, 6) == 0) begin
            ready_gap = $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Keep the output side blocked long enough for the unit to fill up and refuse requests.
    initial begin
        wait (reqs_accepted >= HOLD_AFTER);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("multitap_keypad_text_entry_unit_test NOT OK");
        $finish;
    end

    initial begin
        logic [3:0] k;
        int n;
        queue_confirm(4'd0);
        queue_confirm(4'd15);
        queue_press(KEY_HASH);
        queue_press(4'd15);
        queue_press(4'd12);
        repeat (6) queue_press(4'd1);
        repeat (3) queue_press(4'd0);
        repeat (2) queue_press(KEY_STAR);
        queue_press(KEY_HASH);
        queue_press(4'd13);
        repeat (2) queue_press(4'd9);
        queue_confirm(4'd15);
        queue_press(4'd7);
        queue_press(4'd2);
        queue_confirm(4'd0);
        while (pending_keys.size() < TOTAL_REQS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    k = 4'($urandom_range(0, 10));
                    n = $urandom_range(1, 6);
                    repeat (n) queue_press(k);
                    if ($urandom_range(0, 1) == 1) begin
                        queue_confirm(4'($urandom_range(0, 15)));
                    end
                end
                7: queue_press(4'($urandom_range(11, 15)));
                8: queue_confirm(4'($urandom_range(0, 15)));
                default: begin
                    if ($urandom_range(0, 1) == 1) begin
                        queue_confirm(4'($urandom_range(0, 15)));
                    end else begin
                        queue_press(4'($urandom_range(0, 15)));
                    end
                end
            endcase
        end
        total_reqs = pending_keys.size();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (reqs_accepted == total_reqs);
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (bad_reports == 0) begin
            $display("multitap_keypad_text_entry_unit_test OK");
        end else begin
            $display("multitap_keypad_text_entry_unit_test NOT OK");
        end
        $finish;
    end

endmodule
